// ----- design/rational_arith_gcd_reduce_unit_macros.svh -----
// Assertion macros for the rational GCD reduce unit checker.
// Included by the checker file only.
`ifndef RATIONAL_ARITH_GCD_REDUCE_UNIT_MACROS_SVH
`define RATIONAL_ARITH_GCD_REDUCE_UNIT_MACROS_SVH
// implication checked on every clock, suspended in reset
`define RGR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rgr check failed");
// next-cycle implication
`define RGR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rgr check failed");
`endif

// ----- design/rgr_pkg.sv -----
// Package for the rational GCD reduce unit: payload types, op codes, states.
// No dependencies.
`timescale 1ns / 1ps
package rgr_pkg;
	localparam int OperandWidth = 16;
	localparam int WordWidth = 32;

	typedef enum logic [2:0] {
		KIND_ADD = 3'd0,
		KIND_SUB = 3'd1,
		KIND_MUL = 3'd2,
		KIND_DIV = 3'd3,
		KIND_RED = 3'd4
	} kind_t;

	typedef struct packed {
		logic [2:0] kind;
		logic signed [OperandWidth-1:0] a_num;
		logic signed [OperandWidth-1:0] a_den;
		logic signed [OperandWidth-1:0] b_num;
		logic signed [OperandWidth-1:0] b_den;
	} in_item_t;

	typedef struct packed {
		logic signed [WordWidth-1:0] res_num;
		logic signed [WordWidth-1:0] res_den;
		logic status;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_CHECK,
		ST_EUCLID,
		ST_QNUM,
		ST_QDEN,
		ST_OUT
	} state_t;

	// divider unit request / response
	typedef struct packed {
		logic start;
		logic [WordWidth-1:0] dividend;
		logic [WordWidth-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [WordWidth-1:0] quot;
		logic [WordWidth-1:0] rem;
	} div_rsp_t;
endpackage

// ----- design/rgr_divider.sv -----
// Shared radix-2 restoring divider, truncated signed quotient and remainder.
// Depends on rgr_pkg.
`timescale 1ns / 1ps
module rgr_divider (
	input  logic clk,
	input  logic arst_n,
	input  rgr_pkg::div_req_t req,
	output rgr_pkg::div_rsp_t rsp
);
	localparam int W = rgr_pkg::WordWidth;

	logic busy_q;
	logic [$clog2(W)-1:0] cnt_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] dvs_q;
	logic neg_q_q;
	logic neg_r_q;
	logic done_q;
	logic [W-1:0] mag_a;
	logic [W-1:0] mag_b;
	logic [W:0] trial;

	assign mag_a = req.dividend[W-1] ? (~req.dividend + 1'b1) : req.dividend;
	assign mag_b = req.divisor[W-1] ? (~req.divisor + 1'b1) : req.divisor;
	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

	// one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $clog2(W)'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			quo_q <= mag_a;
			rem_q <= '0;
			dvs_q <= mag_b;
			neg_q_q <= req.dividend[W-1] ^ req.divisor[W-1];
			neg_r_q <= req.dividend[W-1];
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q_q ? (~quo_q + 1'b1) : quo_q;
	assign rsp.rem = neg_r_q ? (~rem_q + 1'b1) : rem_q;
endmodule

// ----- design/rgr_seq.sv -----
// Sequencer: forms raw fraction with one shared multiplier, runs Euclid
// on the shared divider, then divides both parts by the gcd. Uses rgr_pkg.
`timescale 1ns / 1ps
module rgr_seq (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rgr_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rgr_pkg::out_item_t out_data,
	output rgr_pkg::div_req_t dreq,
	input  rgr_pkg::div_rsp_t drsp
);
	localparam int W = rgr_pkg::WordWidth;

	rgr_pkg::state_t state_q, state_d;
	logic [2:0] kind_q;
	logic [W-1:0] an_q, ad_q, bn_q, bd_q;
	logic [W-1:0] num_q, den_q, x_q, y_q;
	logic [W-1:0] mul_a, mul_b, prod;
	logic [2*W-1:0] prod_full;
	logic div_busy_q;
	logic issue;
	logic is_red;

	assign is_red = !(kind_q inside {rgr_pkg::KIND_ADD, rgr_pkg::KIND_SUB,
		rgr_pkg::KIND_MUL, rgr_pkg::KIND_DIV});

	// shared multiplier operand select
	always_comb begin
		mul_a = an_q;
		mul_b = bd_q;
		case (state_q)
			rgr_pkg::ST_MUL0: begin
				mul_a = an_q;
				mul_b = (kind_q == rgr_pkg::KIND_MUL) ? bn_q : bd_q;
			end
			rgr_pkg::ST_MUL1: begin
				mul_a = ad_q;
				mul_b = (kind_q == rgr_pkg::KIND_DIV) ? bn_q : bd_q;
			end
			rgr_pkg::ST_MUL2: begin
				mul_a = ad_q;
				mul_b = bn_q;
			end
			default: begin
				mul_a = an_q;
				mul_b = bd_q;
			end
		endcase
	end
	assign prod_full = mul_a * mul_b;
	assign prod = prod_full[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rgr_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_busy_q <= 1'b0;
		else if (issue) div_busy_q <= 1'b1;
		else if (drsp.done) div_busy_q <= 1'b0;
	end

	// next state and divider issue
	always_comb begin
		state_d = state_q;
		issue = 1'b0;
		dreq.start = 1'b0;
		dreq.dividend = x_q;
		dreq.divisor = y_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			rgr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = rgr_pkg::ST_MUL0;
			end
			rgr_pkg::ST_MUL0: state_d = is_red ? rgr_pkg::ST_CHECK : rgr_pkg::ST_MUL1;
			rgr_pkg::ST_MUL1: state_d = (kind_q == rgr_pkg::KIND_ADD ||
				kind_q == rgr_pkg::KIND_SUB) ? rgr_pkg::ST_MUL2 : rgr_pkg::ST_CHECK;
			rgr_pkg::ST_MUL2: state_d = rgr_pkg::ST_CHECK;
			rgr_pkg::ST_CHECK: state_d = (den_q == '0) ? rgr_pkg::ST_OUT
				: rgr_pkg::ST_EUCLID;
			rgr_pkg::ST_EUCLID: begin
				if (y_q == '0) begin
					state_d = rgr_pkg::ST_QNUM;
				end else if (!div_busy_q) begin
					issue = 1'b1;
				end
			end
			rgr_pkg::ST_QNUM: begin
				dreq.dividend = num_q;
				dreq.divisor = x_q;
				if (!div_busy_q && !drsp.done) issue = 1'b1;
				if (drsp.done) state_d = rgr_pkg::ST_QDEN;
			end
			rgr_pkg::ST_QDEN: begin
				dreq.dividend = den_q;
				dreq.divisor = x_q;
				if (!div_busy_q && !drsp.done) issue = 1'b1;
				if (drsp.done) state_d = rgr_pkg::ST_OUT;
			end
			rgr_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = rgr_pkg::ST_IDLE;
			end
			default: state_d = rgr_pkg::ST_IDLE;
		endcase
		dreq.start = issue;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			rgr_pkg::ST_IDLE: begin
				if (in_valid) begin
					kind_q <= in_data.kind;
					an_q <= W'(in_data.a_num);
					ad_q <= W'(in_data.a_den);
					bn_q <= W'(in_data.b_num);
					bd_q <= W'(in_data.b_den);
				end
			end
			rgr_pkg::ST_MUL0: begin
				if (is_red) begin
					num_q <= an_q;
					den_q <= ad_q;
				end else begin
					num_q <= prod;
				end
			end
			rgr_pkg::ST_MUL1: begin
				den_q <= prod;
			end
			rgr_pkg::ST_MUL2: begin
				num_q <= (kind_q == rgr_pkg::KIND_ADD) ? num_q + prod : num_q - prod;
			end
			rgr_pkg::ST_CHECK: begin
				x_q <= num_q;
				y_q <= den_q;
				out_data.res_num <= '0;
				out_data.res_den <= '0;
				out_data.status <= (den_q == '0);
			end
			rgr_pkg::ST_EUCLID: begin
				if (drsp.done) begin
					x_q <= y_q;
					y_q <= drsp.rem;
				end
			end
			rgr_pkg::ST_QNUM: if (drsp.done) out_data.res_num <= drsp.quot;
			rgr_pkg::ST_QDEN: if (drsp.done) out_data.res_den <= drsp.quot;
			default: ;
		endcase
	end
endmodule

// ----- design/rational_arith_gcd_reduce_unit.sv -----
// Rational arithmetic GCD reduce unit, top level.
// Channels: in (valid/ready, rgr_pkg::in_item_t) and out (valid/ready,
// rgr_pkg::out_item_t). One result transaction per input transaction.
// The block takes one transaction at a time: in_ready is high only while
// idle. The raw fraction is formed with one 32x32 multiplier in the states
// ST_MUL0 to ST_MUL2 as needed, then Euclid's loop runs on a shared radix-2
// divider; each of the k remainder steps is one divider request (issue,
// shift steps, result capture), and two more requests divide both parts
// by the gcd. k stays under about 47 for 32-bit words. A zero raw
// denominator skips the loop and returns status 1 with zero fields.
// Reset (arst_n low) returns the sequencer to idle and drops out_valid.
// When the receiver stalls, the result holds on out_data with out_valid
// high and no new transaction is taken until it is accepted.
// Depends on rgr_pkg, rgr_divider and rgr_seq.
`timescale 1ns / 1ps
module rational_arith_gcd_reduce_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rgr_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rgr_pkg::out_item_t out_data
);
	rgr_pkg::div_req_t dreq;
	rgr_pkg::div_rsp_t drsp;

	rgr_seq u_seq (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.dreq(dreq), .drsp(drsp)
	);

	rgr_divider u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp)
	);
endmodule

// ----- design/rgr_checker.sv -----
// Port-level checker for the rational GCD reduce unit, bound to the top.
// Depends on rgr_pkg and the macros header.
`timescale 1ns / 1ps
`include "rational_arith_gcd_reduce_unit_macros.svh"
module rgr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input rgr_pkg::out_item_t out_data
);
	// one transaction in flight: no input taken while a result waits
	`RGR_ASSERT_IMPL(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	// accepted input makes the block busy next cycle
	`RGR_ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && in_ready, !in_ready)
	// result held while stalled
	`RGR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_data))
	// error result carries zero fields
	`RGR_ASSERT_IMPL(a_err_zero, clk, arst_n, out_valid && out_data.status,
		out_data.res_num == '0 && out_data.res_den == '0)
endmodule

bind rational_arith_gcd_reduce_unit rgr_checker u_rgr_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
